// ----- hw/rtl/integer_to_ascii_formatter_macros.svh -----
// Assertion macros used by the formatter's checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/itaf_pkg.sv -----
package itaf_pkg;

    // Mode codes of an input word.
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEXL = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    // Most digits one value can produce (pointer mode, 64 bits of hex).
    localparam int DIGIT_MAX = 16;
    localparam int CNT_W     = $clog2(DIGIT_MAX + 1);

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> 35.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    // ASCII codes used outside the digit table.
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;

    // Character source select for the output register.
    typedef logic [1:0] t_char_sel;
    localparam t_char_sel CSEL_MINUS = 2'd0;
    localparam t_char_sel CSEL_ZERO  = 2'd1;
    localparam t_char_sel CSEL_X     = 2'd2;
    localparam t_char_sel CSEL_DIGIT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      step;
        logic      emit;
        t_char_sel sel;
        logic      last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic minus;
        logic prefix;
        logic one_left;
        logic out_free;
    } t_dp_stat;

    // Maps one digit to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h37 : 8'h57;
        if (digit < 4'd10) begin
            return CHAR_ZERO + {4'b0000, digit};
        end
        return base + {4'b0000, digit};
    endfunction

endpackage

// ----- hw/rtl/itaf_dpath.sv -----
module itaf_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itaf_pkg::t_dp_cmd   i_cmd,
    output itaf_pkg::t_dp_stat  o_stat,
    input  logic [2:0]          i_mode,
    input  logic [63:0]         i_value,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_text_char,
    output logic                o_last
);
    import itaf_pkg::*;

    logic        r_dec;
    logic        r_upper;
    logic        r_minus;
    logic        r_prefix;
    logic [63:0] r_mag;
    logic [CNT_W-1:0] r_nd;
    logic [3:0]  r_digits [DIGIT_MAX];
    logic        r_o_valid;
    logic [7:0]  r_o_char;
    logic        r_o_last;

    logic [31:0] w_dec_x;
    logic [63:0] w_prod;
    logic [28:0] w_quot;
    logic [31:0] w_rem;
    logic [3:0]  w_digit;
    logic [63:0] w_mag_next;
    logic [31:0] w_low;
    logic        w_out_free;
    logic [7:0]  w_char;

    // One decimal digit per step: divide by ten through the reciprocal.
    assign w_dec_x = r_mag[31:0];
    assign w_prod  = 64'(w_dec_x) * 64'(RECIP10);
    assign w_quot  = w_prod[63:35];
    assign w_rem   = w_dec_x - {w_quot, 3'b000} - {2'b00, w_quot, 1'b0};

    // Hex takes the low nibble and shifts it out.
    always_comb begin
        if (r_dec) begin
            w_digit    = w_rem[3:0];
            w_mag_next = {35'd0, w_quot};
        end else begin
            w_digit    = r_mag[3:0];
            w_mag_next = {4'h0, r_mag[63:4]};
        end
    end

    assign w_low      = i_value[31:0];
    assign w_out_free = !r_o_valid || i_ready;

    // Character chosen for the output register.
    always_comb begin
        case (i_cmd.sel)
            CSEL_MINUS: w_char = CHAR_MINUS;
            CSEL_ZERO:  w_char = CHAR_ZERO;
            CSEL_X:     w_char = CHAR_X;
            default:    w_char = digit_char(r_digits[0], r_upper);
        endcase
    end

    // Capture the value, form its magnitude and count the digits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd <= '0;
        end else if (i_cmd.load) begin
            r_dec    <= (i_mode == MODE_SDEC) || (i_mode == MODE_UDEC);
            r_upper  <= (i_mode == MODE_HEXU);
            r_minus  <= (i_mode == MODE_SDEC) && w_low[31];
            r_prefix <= (i_mode == MODE_PTR);
            r_nd     <= '0;
            if (i_mode == MODE_PTR) begin
                r_mag <= i_value;
            end else if ((i_mode == MODE_SDEC) && w_low[31]) begin
                r_mag <= {32'd0, 32'd0 - w_low};
            end else begin
                r_mag <= {32'd0, w_low};
            end
        end else if (i_cmd.step) begin
            r_mag <= w_mag_next;
            r_nd  <= r_nd + 1'b1;
        end else if (i_cmd.emit && (i_cmd.sel == CSEL_DIGIT)) begin
            r_nd <= r_nd - 1'b1;
        end
    end

    // Digit line: new digits enter at the bottom, so entry 0 holds the most
    // significant digit once conversion ends; emitting shifts back down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_digits[0] <= w_digit;
            for (int i = 1; i < DIGIT_MAX; i++) begin
                r_digits[i] <= r_digits[i-1];
            end
        end else if (i_cmd.emit && (i_cmd.sel == CSEL_DIGIT)) begin
            for (int i = 0; i < DIGIT_MAX - 1; i++) begin
                r_digits[i] <= r_digits[i+1];
            end
            r_digits[DIGIT_MAX-1] <= 4'h0;
        end
    end

    // Output register holds one word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_char <= w_char;
            r_o_last <= i_cmd.last;
        end
    end

    assign o_stat.conv_last = (w_mag_next == 64'd0) || (r_nd == CNT_W'(DIGIT_MAX - 1));
    assign o_stat.minus     = r_minus;
    assign o_stat.prefix    = r_prefix;
    assign o_stat.one_left  = (r_nd == CNT_W'(1));
    assign o_stat.out_free  = w_out_free;

    assign o_valid     = r_o_valid;
    assign o_text_char = r_o_char;
    assign o_last      = r_o_last;

endmodule

// ----- hw/rtl/itaf_ctrl.sv -----
module itaf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_mode,
    output logic                o_ready,
    input  itaf_pkg::t_dp_stat  i_stat,
    output itaf_pkg::t_dp_cmd   o_cmd
);
    import itaf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_PFX0 = 3'd3;
    localparam logic [2:0] ST_PFX1 = 3'd4;
    localparam logic [2:0] ST_DIG  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_mode_ok;

    assign w_mode_ok = (i_mode <= MODE_PTR);
    assign o_ready   = (r_state == ST_IDLE);

    // Sequencer: convert all digits, then emit sign or prefix and digits.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = CSEL_DIGIT;
        unique case (r_state)
            ST_IDLE: begin
                // Words with an unused mode are taken and dropped.
                if (i_valid && w_mode_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_last) begin
                    if (i_stat.minus) begin
                        n_state = ST_SIGN;
                    end else if (i_stat.prefix) begin
                        n_state = ST_PFX0;
                    end else begin
                        n_state = ST_DIG;
                    end
                end
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = CSEL_MINUS;
                    n_state    = ST_DIG;
                end
            end
            ST_PFX0: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = CSEL_ZERO;
                    n_state    = ST_PFX1;
                end
            end
            ST_PFX1: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = CSEL_X;
                    n_state    = ST_DIG;
                end
            end
            ST_DIG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = CSEL_DIGIT;
                    o_cmd.last = i_stat.one_left;
                    if (i_stat.one_left) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// A word is taken in idle and converted one digit per step (up to 10 decimal, 8 hex or
// 16 pointer digits), then one character per cycle goes into the output register while it is free.
// Text is an optional sign or prefix followed by the digits; each decimal digit step is
// one pass through the divide-by-ten multiplier, and each hex digit step is a nibble shift.
// The next word is taken while the last character still waits in the output register.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last
);
    import itaf_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    itaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Digit conversion and output register.
    itaf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

endmodule

// ----- hw/rtl/itaf_checker.sv -----
`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_mode,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_text_char,
    input logic        o_last
);
    import itaf_pkg::*;

    logic       w_out_stall;
    logic [8:0] w_word;
    logic       w_take;
    logic       w_last_out;
    logic       w_mark;

    // Terms built from the port values.
    assign w_out_stall = o_valid && !i_ready;
    assign w_word      = {o_text_char, o_last};
    assign w_take      = i_valid && o_ready && (i_mode <= MODE_PTR);
    assign w_last_out  = o_valid && o_last;
    assign w_mark      = (o_text_char == CHAR_MINUS) || (o_text_char == CHAR_X);

    // A stalled output word holds its contents.
    `ITAF_ASSERT_NEXT(a_out_hold, w_out_stall, o_valid && $stable(w_word), "stalled word changed")

    // Taking a word with a valid mode makes the block busy.
    `ITAF_ASSERT_NEXT(a_busy_after_take, w_take, !o_ready, "block not busy after a take")

    // The block becomes ready again only with the final character on show.
    `ITAF_ASSERT_NOW(a_rdy_last, $rose(o_ready) && $past(i_rst_n), w_last_out, "ready rose early")

    // Text never ends on a sign or on the pointer prefix.
    `ITAF_ASSERT_NOW(a_last_is_digit, w_last_out, !w_mark, "text ended on a sign or prefix")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_mode      (i_mode),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_text_char (o_text_char),
    .o_last      (o_last)
);

// ----- tb/tb_integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
    import itaf_pkg::*;

    // Mode codes that the block must ignore.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // Letter bases for hex digits ten through fifteen.
    localparam logic [7:0] LETTER_LOWER = 8'h61;
    localparam logic [7:0] LETTER_UPPER = 8'h41;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_WORDS   = 450;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 120;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_PRINTED    = 40;

    // Receiver stall styles.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_style;

    typedef struct {
        logic [2:0]  mode;
        logic [63:0] value;
    } t_fmt_word;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_mode;
    logic [63:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_text_char;
    logic        o_last;

    t_fmt_word  pending_words[$];
    t_text_char expected_text[$];
    t_fmt_word  drv_word;

    int n_words;
    int n_accepted;
    int n_errors;
    int cycle_count;
    int burst_left;
    int gap_left;
    int rx_left;
    int rx_phase;
    t_rx_style rx_style;
    logic      rx_hold;

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Prints one mismatch line, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        n_errors++;
    endtask

    // Maps one digit to its character.
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return (upper ? LETTER_UPPER : LETTER_LOWER) + {4'b0000, d - 4'd10};
    endfunction

    // Formats one word and queues its characters in the order they leave the block.
    task automatic push_expected_text(input logic [2:0] mode, input logic [63:0] value);
        logic [63:0] mag;
        logic [31:0] low;
        logic [63:0] base;
        logic        upper;
        logic        minus;
        logic        prefix;
        logic [7:0]  digits[$];
        t_text_char  line[$];
        t_text_char  tc;
        low    = value[31:0];
        upper  = 1'b0;
        minus  = 1'b0;
        prefix = 1'b0;
        case (mode)
            MODE_SDEC: begin
                base  = 64'd10;
                minus = low[31];
                mag   = low[31] ? {32'd0, 32'd0 - low} : {32'd0, low};
            end
            MODE_UDEC: begin
                base = 64'd10;
                mag  = {32'd0, low};
            end
            MODE_HEXL: begin
                base = 64'd16;
                mag  = {32'd0, low};
            end
            MODE_HEXU: begin
                base  = 64'd16;
                mag   = {32'd0, low};
                upper = 1'b1;
            end
            MODE_PTR: begin
                base   = 64'd16;
                mag    = value;
                prefix = 1'b1;
            end
            default: begin
                // Unused modes produce no text at all.
                return;
            end
        endcase
        // Digits come out least significant first, so build the string front-wards.
        do begin
            digits.push_front(digit_to_ascii(4'(mag % base), upper));
            mag = mag / base;
        end while (mag != 64'd0 && digits.size() < DIGIT_MAX);
        tc.last = 1'b0;
        if (minus) begin
            tc.ch = CHAR_MINUS;
            line.push_back(tc);
        end
        if (prefix) begin
            tc.ch = CHAR_ZERO;
            line.push_back(tc);
            tc.ch = CHAR_X;
            line.push_back(tc);
        end
        foreach (digits[i]) begin
            tc.ch = digits[i];
            line.push_back(tc);
        end
        line[line.size() - 1].last = 1'b1;
        foreach (line[i]) begin
            expected_text.push_back(line[i]);
        end
    endtask

    task automatic add_word(input logic [2:0] mode, input logic [63:0] value);
        t_fmt_word w;
        w.mode  = mode;
        w.value = value;
        pending_words.push_back(w);
        n_words++;
    endtask

    // Picks a value from a mix of shapes that stress digit counts and sign handling.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [31:0] p10;
        int          k;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = {($urandom_range(0, 1) == 0) ? 32'd0 : $urandom,
                    32'($urandom_range(0, 20))};
            2: v = 64'd1 << $urandom_range(0, 63);
            3: v = ~64'd0 >> $urandom_range(0, 63);
            4: begin
                p10 = 32'd1;
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++) begin
                    p10 = p10 * 32'd10;
                end
                v = {$urandom, p10 + 32'($urandom_range(0, 2)) - 32'd1};
            end
            default: begin
                v = ($urandom_range(0, 1) == 0)
                    ? {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 3))}
                    : {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
            end
        endcase
        return v;
    endfunction

    // Sender: offers queued words in bursts with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                push_expected_text(drv_word.mode, drv_word.value);
                n_accepted++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    drv_word = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_mode  <= drv_word.mode;
                    i_value <= drv_word.value;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(0, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a changing pattern and checks every accepted character.
    always @(posedge i_clk) begin
        t_text_char exp_char;
        logic       rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              o_text_char, o_last));
                end else begin
                    exp_char = expected_text.pop_front();
                    if (o_text_char !== exp_char.ch) begin
                        report_mismatch($sformatf("text_char got 0x%02h want 0x%02h",
                                                  o_text_char, exp_char.ch));
                    end
                    if (o_last !== exp_char.last) begin
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  o_last, exp_char.last));
                    end
                end
            end
            if (rx_left > 0) begin
                rx_left--;
            end else begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_left  = $urandom_range(64, 256);
            end
            rx_phase = (rx_phase + 1) % 7;
            case (rx_style)
                RX_ALWAYS:   rdy = 1'b1;
                RX_HALF:     rdy = ($urandom_range(0, 1) == 0);
                RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
                default:     rdy = (rx_phase < 3);
            endcase
            i_ready <= rdy && !rx_hold;
        end
    end

    // Long receiver hold-off so that the block backs up and stalls its input.
    initial begin
        rx_hold = 1'b0;
        while (n_accepted < HOLD_AFTER) begin
            @(posedge i_clk);
        end
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_SDEC;
        i_value     = 64'd0;
        i_ready     = 1'b0;
        n_words     = 0;
        n_accepted  = 0;
        n_errors    = 0;
        cycle_count = 0;
        burst_left  = 4;
        gap_left    = 0;
        rx_left     = 0;
        rx_phase    = 0;
        rx_style    = RX_ALWAYS;

        // Directed words: field extremes, every mode, and the special cases.
        add_word(MODE_SDEC, 64'd0);
        add_word(MODE_SDEC, 64'd1);
        add_word(MODE_SDEC, 64'h0000_0000_FFFF_FFFF);
        add_word(MODE_SDEC, 64'h0000_0000_7FFF_FFFF);
        add_word(MODE_SDEC, 64'h0000_0000_8000_0000);
        add_word(MODE_SDEC, 64'hDEAD_BEEF_0000_0005);
        add_word(MODE_UDEC, 64'd0);
        add_word(MODE_UDEC, 64'h0000_0000_FFFF_FFFF);
        add_word(MODE_UDEC, 64'd1000000000);
        add_word(MODE_UDEC, 64'hFFFF_FFFF_0000_0009);
        add_word(MODE_HEXL, 64'd0);
        add_word(MODE_HEXL, 64'h0000_0000_FFFF_FFFF);
        add_word(MODE_HEXL, 64'h1234_5678_ABCD_EF01);
        add_word(MODE_HEXU, 64'h0000_0000_ABCD_EF01);
        add_word(MODE_HEXU, 64'hFFFF_FFFF_0000_0000);
        add_word(MODE_PTR,  64'd0);
        add_word(MODE_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
        add_word(MODE_PTR,  64'h8000_0000_0000_0000);
        add_word(MODE_PTR,  64'h1234_5678_9ABC_DEF0);
        add_word(MODE_PTR,  64'h0000_0000_0000_000F);
        add_word(MODE_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(3'd6, 64'd12345);
        add_word(MODE_UNUSED_HI, 64'd0);

        // Random words, mostly valid modes with a few ignored ones mixed in.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_word(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), random_value());
            end else begin
                add_word(3'($urandom_range(MODE_SDEC, MODE_PTR)), random_value());
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == n_words && expected_text.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_text.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
        end
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/itaf_pkg.sv
hw/rtl/itaf_dpath.sv
hw/rtl/itaf_ctrl.sv
hw/rtl/integer_to_ascii_formatter.sv
hw/rtl/itaf_checker.sv
tb/tb_integer_to_ascii_formatter.sv
